>>> sv/sorted_key_table_assert.svh
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define SKT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define SKT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/skt_pkg.sv
package skt_pkg;

  localparam int KEY_W   = 8;
  localparam int CMD_W   = 2;
  localparam int ST_W    = 2;
  localparam int POS_W   = 5;
  localparam int TOTAL_W = 6;
  localparam int OP_W    = 2;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  // cell operations
  localparam logic [OP_W-1:0] OP_HOLD = 2'd0;
  localparam logic [OP_W-1:0] OP_INS  = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
  } skt_ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } skt_srch_t;

endpackage

>>> sv/skt_cell.sv
module skt_cell (
  input  logic                         clk,
  input  skt_pkg::skt_ctl_t            ctl,
  input  logic                         live,
  input  logic [skt_pkg::KEY_W-1:0]    prev_key,
  input  logic                         prev_keep,
  input  logic [skt_pkg::KEY_W-1:0]    next_key,
  output logic [skt_pkg::KEY_W-1:0]    key_q,
  output logic                         keep,
  output logic                         eq
);

  logic [skt_pkg::KEY_W-1:0] key_r;
  logic [skt_pkg::KEY_W-1:0] key_nxt;

  // keep: live entry strictly below the item key, stays in place
  assign keep  = live && (key_r < ctl.key);
  assign eq    = live && (key_r == ctl.key);
  assign key_q = key_r;

  always_comb begin
    key_nxt = key_r;
    unique case (ctl.op)
      skt_pkg::OP_INS: begin
        if (!keep) key_nxt = prev_keep ? ctl.key : prev_key;
      end
      skt_pkg::OP_DEL: begin
        if (!keep) key_nxt = next_key;
      end
      default: key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

>>> sv/skt_search.sv
module skt_search #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              start,
  input  logic                              step,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]  count,
  input  logic [TABLE_DEPTH-1:0]            keep_vec,
  input  logic [TABLE_DEPTH-1:0]            eq_vec,
  output skt_pkg::skt_srch_t                res,
  output logic [$clog2(TABLE_DEPTH)-1:0]    pos
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH+1);

  // end_r is one past the upper bound of the window
  logic [CW-1:0] lo_r,  lo_nxt;
  logic [CW-1:0] end_r, end_nxt;
  logic [CW-1:0] diff;
  logic [CW-1:0] mid;
  logic [IW-1:0] idx;
  logic          open;

  always_comb begin
    open     = lo_r < end_r;
    diff     = end_r - lo_r - CW'(1);
    mid      = lo_r + (diff >> 1);
    idx      = mid[IW-1:0];
    res.hit  = open && eq_vec[idx];
    res.done = !open || eq_vec[idx];
    pos      = idx;
  end

  always_comb begin
    lo_nxt  = lo_r;
    end_nxt = end_r;
    if (start) begin
      lo_nxt  = '0;
      end_nxt = count;
    end else if (step) begin
      if (keep_vec[idx]) lo_nxt  = mid + CW'(1);
      else               end_nxt = mid;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    end_r <= end_nxt;
  end

endmodule

>>> sv/sorted_key_table.sv
// Insert, delete and clear: S_EXEC registers the result once the output register is free.
// Lookup: S_EXEC starts a binary search, then S_SRCH probes one entry a cycle until it is done.
// One item in flight; the next is accepted once the previous result is in the output
// register, so a new item is never taken while the last one is still being worked on.
// Reset clears the entry count and the handshake state; key cells are not cleared.
module sorted_key_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [skt_pkg::CMD_W-1:0]      in_command,
  input  logic [skt_pkg::KEY_W-1:0]      in_key,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [skt_pkg::ST_W-1:0]       out_status,
  output logic [skt_pkg::POS_W-1:0]      out_position,
  output logic [skt_pkg::TOTAL_W-1:0]    out_entry_total
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH+1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [skt_pkg::CMD_W-1:0]     cmd_r;
  logic [skt_pkg::KEY_W-1:0]     key_r;
  logic [CW-1:0]                 count_r, count_nxt;
  logic                          out_valid_r;
  logic [skt_pkg::ST_W-1:0]      out_status_r;
  logic [skt_pkg::POS_W-1:0]     out_position_r;
  logic [skt_pkg::TOTAL_W-1:0]   out_entry_total_r;

  skt_pkg::skt_ctl_t             ctl;
  logic [TABLE_DEPTH-1:0]        live_vec;
  logic [TABLE_DEPTH-1:0]        keep_vec;
  logic [TABLE_DEPTH-1:0]        eq_vec;
  logic [TABLE_DEPTH:0]          keep_ext;
  logic [skt_pkg::KEY_W-1:0]     key_ext [TABLE_DEPTH+2];
  logic [TABLE_DEPTH-1:0]        bound;
  logic [IW-1:0]                 bound_pos;

  skt_pkg::skt_srch_t            srch;
  logic [IW-1:0]                 srch_pos;
  logic                          srch_start;
  logic                          srch_step;

  logic                          out_free;
  logic                          full;
  logic                          hit;
  logic                          res_fire;
  logic [skt_pkg::ST_W-1:0]      res_status;
  logic [skt_pkg::POS_W-1:0]     res_pos;

  // chain ends: on an insert, cell 0 takes the new key unless it keeps its own
  assign keep_ext[0]           = 1'b1;
  assign key_ext[0]            = '0;
  assign key_ext[TABLE_DEPTH+1] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    assign live_vec[g]   = count_r > CW'(g);
    assign keep_ext[g+1] = keep_vec[g];

    skt_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .live      (live_vec[g]),
      .prev_key  (key_ext[g]),
      .prev_keep (keep_ext[g]),
      .next_key  (key_ext[g+2]),
      .key_q     (key_ext[g+1]),
      .keep      (keep_vec[g]),
      .eq        (eq_vec[g])
    );
  end

  skt_search #(.TABLE_DEPTH(TABLE_DEPTH)) u_search (
    .clk      (clk),
    .start    (srch_start),
    .step     (srch_step),
    .count    (count_r),
    .keep_vec (keep_vec),
    .eq_vec   (eq_vec),
    .res      (srch),
    .pos      (srch_pos)
  );

  // first entry not below the key: the keep run is a prefix, so at most one bit is set
  always_comb begin
    bound     = ~keep_vec & keep_ext[TABLE_DEPTH-1:0];
    bound_pos = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (bound[i]) bound_pos = bound_pos | IW'(i);
    end
  end

  always_comb begin
    out_free   = !out_valid_r || out_ready;
    in_ready   = state_r == S_IDLE;
    full       = count_r == CW'(TABLE_DEPTH);
    hit        = |eq_vec;
    srch_start = (state_r == S_EXEC) && (cmd_r == skt_pkg::CMD_LOOKUP);
    srch_step  = (state_r == S_SRCH) && !srch.done;

    ctl.key = key_r;
    ctl.op  = skt_pkg::OP_HOLD;
    if (state_r == S_EXEC && out_free) begin
      if (cmd_r == skt_pkg::CMD_INSERT && !full) ctl.op = skt_pkg::OP_INS;
      if (cmd_r == skt_pkg::CMD_DELETE && hit)   ctl.op = skt_pkg::OP_DEL;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    res_fire   = 1'b0;
    res_status = skt_pkg::ST_OK;
    res_pos    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_r == skt_pkg::CMD_LOOKUP) begin
          state_nxt = S_SRCH;
        end else if (out_free) begin
          res_fire  = 1'b1;
          state_nxt = S_IDLE;
          unique case (cmd_r)
            skt_pkg::CMD_INSERT: begin
              if (full) begin
                res_status = skt_pkg::ST_FULL;
              end else begin
                res_pos   = skt_pkg::POS_W'(bound_pos);
                count_nxt = count_r + CW'(1);
              end
            end
            skt_pkg::CMD_DELETE: begin
              if (hit) begin
                res_pos   = skt_pkg::POS_W'(bound_pos);
                count_nxt = count_r - CW'(1);
              end else begin
                res_status = skt_pkg::ST_MISS;
              end
            end
            skt_pkg::CMD_CLEAR: count_nxt = '0;
            default: res_status = skt_pkg::ST_OK;
          endcase
        end
      end
      S_SRCH: begin
        if (srch.done && out_free) begin
          res_fire  = 1'b1;
          state_nxt = S_IDLE;
          if (srch.hit) res_pos    = skt_pkg::POS_W'(srch_pos);
          else          res_status = skt_pkg::ST_MISS;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (res_fire)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_command;
      key_r <= in_key;
    end
    if (res_fire) begin
      out_status_r      <= res_status;
      out_position_r    <= res_pos;
      out_entry_total_r <= skt_pkg::TOTAL_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = out_position_r;
  assign out_entry_total = out_entry_total_r;

endmodule

>>> sv/skt_checker.sv
`include "sorted_key_table_assert.svh"

module skt_checker #(
  parameter int TABLE_DEPTH = 32
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [skt_pkg::ST_W-1:0]     out_status,
  input logic [skt_pkg::POS_W-1:0]    out_position,
  input logic [skt_pkg::TOTAL_W-1:0]  out_entry_total
);

  `SKT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  `SKT_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")

  `SKT_ASSERT_IMP(a_status_code, out_valid, out_status == skt_pkg::ST_OK || out_status == skt_pkg::ST_MISS || out_status == skt_pkg::ST_FULL, "bad status code")

  `SKT_ASSERT_IMP(a_miss_pos, out_valid && out_status == skt_pkg::ST_MISS, out_position == '0, "miss with nonzero position")

  `SKT_ASSERT_IMP(a_full_total, out_valid && out_status == skt_pkg::ST_FULL, out_entry_total == skt_pkg::TOTAL_W'(TABLE_DEPTH), "full refusal with table not full")

endmodule

bind sorted_key_table skt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_skt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_position    (out_position),
  .out_entry_total (out_entry_total)
);

>>> tb/sv/sorted_key_table_checker.sv
`timescale 1ns / 100ps

module sorted_key_table_checker import skt_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [KEY_W-1:0]   in_key,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [ST_W-1:0]    out_status,
  input  logic [POS_W-1:0]   out_position,
  input  logic [TOTAL_W-1:0] out_entry_total,
  output int                 mismatch_count,
  output int                 pending_count
);

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [POS_W-1:0]   position;
    logic [TOTAL_W-1:0] entry_total;
  } key_result_t;

  logic [KEY_W-1:0] stored_keys [TABLE_DEPTH];
  int               live_count;
  key_result_t      result_q [$];
  key_result_t      want;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    live_count     = 0;
  end

  // binary search as the block does it; with duplicates it may not hit the lowest index
  function automatic int search_equal(logic [KEY_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = live_count - 1;
    while (lo <= hi) begin
      mid = lo + ((hi - lo) >>> 1);
      if (stored_keys[mid] < key)
        lo = mid + 1;
      else if (stored_keys[mid] > key)
        hi = mid - 1;
      else
        return mid;
    end
    return -1;
  endfunction

  function automatic int first_not_less(logic [KEY_W-1:0] key);
    int i;
    i = 0;
    while (i < live_count && stored_keys[i] < key)
      i++;
    return i;
  endfunction

  function automatic key_result_t apply_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
    key_result_t r;
    int          p;
    int          i;
    r.status   = ST_OK;
    r.position = '0;
    case (cmd)
      CMD_LOOKUP: begin
        p = search_equal(key);
        if (p < 0)
          r.status = ST_MISS;
        else
          r.position = p[POS_W-1:0];
      end
      CMD_INSERT: begin
        if (live_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          p = first_not_less(key);
          for (i = live_count; i > p; i--)
            stored_keys[i] = stored_keys[i-1];
          stored_keys[p] = key;
          live_count++;
          r.position = p[POS_W-1:0];
        end
      end
      CMD_DELETE: begin
        if (search_equal(key) < 0) begin
          r.status = ST_MISS;
        end else begin
          // the first equal entry goes, not necessarily the one the search met
          p = first_not_less(key);
          for (i = p; i < live_count - 1; i++)
            stored_keys[i] = stored_keys[i+1];
          live_count--;
          r.position = p[POS_W-1:0];
        end
      end
      CMD_CLEAR: begin
        live_count = 0;
      end
    endcase
    r.entry_total = live_count[TOTAL_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      live_count = 0;
      result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result: status %0d position %0d total %0d",
                   $time, out_status, out_position, out_entry_total);
          mismatch_count++;
        end else begin
          want = result_q.pop_front();
          if ({out_status, out_position, out_entry_total} !== want) begin
            $display("%0t: result mismatch: expected status %0d position %0d total %0d, got status %0d position %0d total %0d",
                     $time, want.status, want.position, want.entry_total,
                     out_status, out_position, out_entry_total);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready)
        result_q.push_back(apply_command(in_command, in_key));
    end
    pending_count = result_q.size();
  end

endmodule

>>> tb/sv/sorted_key_table_tb.sv
`timescale 1ns / 100ps

module sorted_key_table_tb;
  import skt_pkg::*;

  localparam int TABLE_DEPTH  = 32;
  localparam int ITEM_TARGET  = 1700;

  typedef enum {MIX_FILL, MIX_MIXED, MIX_DRAIN} mix_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [CMD_W-1:0]   in_command;
  logic [KEY_W-1:0]   in_key;
  logic               out_valid;
  logic               out_ready;
  logic [ST_W-1:0]    out_status;
  logic [POS_W-1:0]   out_position;
  logic [TOTAL_W-1:0] out_entry_total;
  int                 mismatch_count;
  int                 pending_count;

  sorted_key_table #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_key(in_key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_position(out_position),
    .out_entry_total(out_entry_total)
  );

  sorted_key_table_checker #(.TABLE_DEPTH(TABLE_DEPTH)) checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_key(in_key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_position(out_position),
    .out_entry_total(out_entry_total),
    .mismatch_count(mismatch_count),
    .pending_count(pending_count)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                           input bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command = cmd;
    in_key     = key;
    in_valid   = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // result side: random stall per item, with occasional stretches of no stall
  initial begin : result_side
    int stall;
    int calm_left;
    out_ready = 1'b0;
    calm_left = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (calm_left > 0) begin
        stall = 0;
        calm_left--;
      end else begin
        stall = $urandom_range(0, 6);
        if ($urandom_range(0, 9) == 0)
          calm_left = $urandom_range(20, 60);
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : item_side
    mix_t             mix;
    int               items_sent;
    int               seg_len;
    int               key_lo;
    int               key_hi;
    int               roll;
    bit               calm;
    bit               first;
    logic [CMD_W-1:0] cmd;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_command = CMD_LOOKUP;
    in_key     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, key extremes, duplicates, misses, clear
    send_item(CMD_LOOKUP, 8'h00, 1'b0);
    send_item(CMD_DELETE, 8'h55, 1'b0);
    send_item(CMD_INSERT, 8'h80, 1'b0);
    send_item(CMD_INSERT, 8'h00, 1'b0);
    send_item(CMD_INSERT, 8'hFF, 1'b0);
    send_item(CMD_INSERT, 8'h80, 1'b0);
    send_item(CMD_INSERT, 8'h80, 1'b0);
    send_item(CMD_LOOKUP, 8'h80, 1'b0);
    send_item(CMD_LOOKUP, 8'hFF, 1'b0);
    send_item(CMD_LOOKUP, 8'h00, 1'b0);
    send_item(CMD_LOOKUP, 8'h7F, 1'b0);
    send_item(CMD_DELETE, 8'h80, 1'b0);
    send_item(CMD_DELETE, 8'h42, 1'b0);
    send_item(CMD_INSERT, 8'hAA, 1'b0);
    send_item(CMD_INSERT, 8'h55, 1'b0);
    send_item(CMD_LOOKUP, 8'h55, 1'b0);
    send_item(CMD_DELETE, 8'hFF, 1'b0);
    send_item(CMD_DELETE, 8'h00, 1'b0);
    send_item(CMD_CLEAR,  8'hA5, 1'b0);
    send_item(CMD_LOOKUP, 8'h80, 1'b0);
    send_item(CMD_INSERT, 8'h01, 1'b0);
    send_item(CMD_CLEAR,  8'h5A, 1'b0);
    drain_results();

    items_sent = 22;
    first = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      // first segment fills the table well past full
      mix     = first ? MIX_FILL : mix_t'($urandom_range(0, 2));
      seg_len = first ? 70 : $urandom_range(20, 80);
      case (first ? 0 : $urandom_range(0, 3))
        0: begin key_lo = 0;   key_hi = 255; end
        1: begin key_lo = 0;   key_hi = 7;   end
        2: begin key_lo = 248; key_hi = 255; end
        default: begin
          key_lo = $urandom_range(0, 240);
          key_hi = key_lo + 15;
        end
      endcase
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0)
        drain_results();
      if (first || $urandom_range(0, 4) == 0) begin
        send_item(CMD_CLEAR, KEY_W'($urandom_range(0, 255)), calm);
        items_sent++;
      end
      repeat (seg_len) begin
        roll = $urandom_range(0, 99);
        case (mix)
          MIX_FILL:
            cmd = roll < 80 ? CMD_INSERT : roll < 90 ? CMD_LOOKUP :
                  roll < 98 ? CMD_DELETE : CMD_CLEAR;
          MIX_MIXED:
            cmd = roll < 35 ? CMD_INSERT : roll < 70 ? CMD_LOOKUP :
                  roll < 98 ? CMD_DELETE : CMD_CLEAR;
          default:
            cmd = roll < 13 ? CMD_INSERT : roll < 33 ? CMD_LOOKUP :
                  roll < 98 ? CMD_DELETE : CMD_CLEAR;
        endcase
        send_item(cmd, KEY_W'($urandom_range(key_lo, key_hi)), calm);
        items_sent++;
      end
      first = 1'b0;
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/skt_pkg.sv
sv/skt_cell.sv
sv/skt_search.sv
sv/sorted_key_table.sv
sv/skt_checker.sv
tb/sv/sorted_key_table_checker.sv
tb/sv/sorted_key_table_tb.sv
